// File: src/drp_pkg.sv
// ----------------------------------------------------------------------------
// drp_pkg - shared types and constants for the digest response parser
// Codes, the status word table and the result beat layout used by the parser
// core, the result queue and the top level.
// ----------------------------------------------------------------------------
package drp_pkg;

    // Record counter width
    localparam int COUNT_WIDTH = 16;
    localparam int SEEN_W      = 16;
    localparam int CMP_W       = (COUNT_WIDTH > SEEN_W) ? COUNT_WIDTH : SEEN_W;

    // Result queue geometry
    localparam int FIFO_DEPTH = 4;
    localparam int PTR_W      = 2;
    localparam int LVL_W      = 3;

    // Parser phases
    localparam logic [1:0] PH_STATUS = 2'd0;
    localparam logic [1:0] PH_NONCE  = 2'd1;
    localparam logic [1:0] PH_CR     = 2'd2;
    localparam logic [1:0] PH_DRAIN  = 2'd3;

    // Result kinds
    localparam logic [1:0] KIND_NONCE   = 2'd0;
    localparam logic [1:0] KIND_REC_END = 2'd1;
    localparam logic [1:0] KIND_MSG_END = 2'd2;

    // Record status codes
    localparam logic [1:0] ST_CONFIRMED = 2'd0;
    localparam logic [1:0] ST_INVALID   = 2'd1;
    localparam logic [1:0] ST_UNKNOWN   = 2'd2;

    // Verdict codes
    localparam logic [2:0] V_OK      = 3'd0;
    localparam logic [2:0] V_BADWORD = 3'd1;
    localparam logic [2:0] V_NOLF    = 3'd2;
    localparam logic [2:0] V_EMPTY   = 3'd3;
    localparam logic [2:0] V_UNTERM  = 3'd4;
    localparam logic [2:0] V_TRAIL   = 3'd5;
    localparam logic [2:0] V_COUNT   = 3'd6;

    // Delimiters
    localparam logic [7:0] CH_EQ = 8'h3D;
    localparam logic [7:0] CH_CR = 8'h0D;
    localparam logic [7:0] CH_LF = 8'h0A;

    // Configuration register indexes
    localparam logic REG_EXPECTED_COUNT = 1'b0;

    // One result beat
    typedef struct packed {
        logic [1:0]        kind;
        logic [7:0]        nonce_byte;
        logic [1:0]        entry_status;
        logic [2:0]        verdict;
        logic [SEEN_W-1:0] records_seen;
        logic              last_of_run;
    } t_result;

    // Results produced by one accepted byte
    typedef struct packed {
        logic [1:0] cnt;
        t_result    r0;
        t_result    r1;
    } t_push;

    // Length of each status word
    function automatic logic [3:0] word_len(input logic [1:0] idx);
        logic [3:0] len;
        unique case (idx)
            ST_CONFIRMED: len = 4'd9;
            ST_INVALID:   len = 4'd7;
            ST_UNKNOWN:   len = 4'd7;
            default:      len = 4'd0;
        endcase
        return len;
    endfunction

    // Lower-case text of each status word; zero beyond its end
    function automatic logic [7:0] word_char(input logic [1:0] idx, input logic [3:0] pos);
        logic [7:0] ch;
        ch = 8'h00;
        unique case (idx)
            ST_CONFIRMED: begin
                unique case (pos)
                    4'd0: ch = "c";
                    4'd1: ch = "o";
                    4'd2: ch = "n";
                    4'd3: ch = "f";
                    4'd4: ch = "i";
                    4'd5: ch = "r";
                    4'd6: ch = "m";
                    4'd7: ch = "e";
                    4'd8: ch = "d";
                    default: ch = 8'h00;
                endcase
            end
            ST_INVALID: begin
                unique case (pos)
                    4'd0: ch = "i";
                    4'd1: ch = "n";
                    4'd2: ch = "v";
                    4'd3: ch = "a";
                    4'd4: ch = "l";
                    4'd5: ch = "i";
                    4'd6: ch = "d";
                    default: ch = 8'h00;
                endcase
            end
            ST_UNKNOWN: begin
                unique case (pos)
                    4'd0: ch = "u";
                    4'd1: ch = "n";
                    4'd2: ch = "k";
                    4'd3: ch = "n";
                    4'd4: ch = "o";
                    4'd5: ch = "w";
                    4'd6: ch = "n";
                    default: ch = 8'h00;
                endcase
            end
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

endpackage

// File: src/digest_response_record_parser.sv
// ----------------------------------------------------------------------------
// digest_response_record_parser - streaming digest response payload parser
// Parses status=nonce CR LF records one byte a cycle when ready, passes nonce
// bytes on, reports record ends and a verdict on the last byte of each message.
// ----------------------------------------------------------------------------
// Result beats are registered in the result queue and offered in arrival order.
// Throughput: one byte a cycle while the queue has room for two beats; a byte
//   yielding two beats (a record end or nonce byte with the verdict) fills two
//   slots of the 4-beat result queue, which drains one beat a cycle on i_ready.
// Reset: synchronous, active low; parse state and queue clear, expected_count
//   returns to 1.
module digest_response_record_parser (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Input byte channel
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_end_of_message,
    // Result channel
    output logic        o_valid,
    input  logic        i_ready,
    output logic [1:0]  o_kind,
    output logic [7:0]  o_nonce_byte,
    output logic [1:0]  o_entry_status,
    output logic [2:0]  o_verdict,
    output logic [15:0] o_records_seen,
    output logic        o_last_of_run,
    // Configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import drp_pkg::*;

    logic [15:0]      r_expected_count;
    logic             accept;
    logic             pop;
    t_push            push;
    t_result          head;
    logic [LVL_W-1:0] level;

    // Configuration register
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_expected_count <= 16'd1;
        end else if (psel && penable && pwrite && paddr[2] == REG_EXPECTED_COUNT) begin
            r_expected_count <= pwdata[15:0];
        end
    end

    assign prdata = (paddr[2] == REG_EXPECTED_COUNT) ? {16'd0, r_expected_count} : 32'd0;

    // Take a byte while the queue has room for two beats
    assign o_ready = (level <= LVL_W'(FIFO_DEPTH - 2));
    assign accept  = i_valid && o_ready;
    assign o_valid = (level != '0);
    assign pop     = o_valid && i_ready;

    drp_parse u_parse (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_accept         (accept),
        .i_data_byte      (i_data_byte),
        .i_end_of_message (i_end_of_message),
        .i_expected_count (r_expected_count),
        .o_push           (push)
    );

    drp_resq u_resq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (pop),
        .o_head  (head),
        .o_level (level)
    );

    assign o_kind         = head.kind;
    assign o_nonce_byte   = head.nonce_byte;
    assign o_entry_status = head.entry_status;
    assign o_verdict      = head.verdict;
    assign o_records_seen = head.records_seen;
    assign o_last_of_run  = head.last_of_run;

    // Every message end yields a verdict beat
    a_eom_pushes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_end_of_message) |-> (push.cnt != 2'd0))
        else $error("message end produced no result beat");

    // Two beats from one byte only on a message end
    a_pair_on_eom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push.cnt == 2'd2) |-> (accept && i_end_of_message))
        else $error("two beats pushed without a message end");

    // The queue never overfills
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (level <= LVL_W'(FIFO_DEPTH)))
        else $error("result queue overflow");

    // A verdict beat always closes its run
    a_verdict_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_kind == KIND_MSG_END) |-> o_last_of_run)
        else $error("verdict beat not marked last");

endmodule

// File: src/drp_parse.sv
// ----------------------------------------------------------------------------
// drp_parse - per-byte record parser
// Holds the parse state and turns each accepted byte into up to two result
// beats for the result queue.
// ----------------------------------------------------------------------------
module drp_parse (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_accept,
    input  logic [7:0]          i_data_byte,
    input  logic                i_end_of_message,
    input  logic [15:0]         i_expected_count,
    output drp_pkg::t_push      o_push
);
    import drp_pkg::*;

    logic [1:0]             r_phase,    n_phase;
    logic [3:0]             r_pos,      n_pos;
    logic [2:0]             r_mask,     n_mask;
    logic [1:0]             r_status,   n_status;
    logic                   r_nonempty, n_nonempty;
    logic [COUNT_WIDTH-1:0] r_count,    n_count;
    logic                   r_ovf,      n_ovf;
    logic [2:0]             r_err,      n_err;

    logic [7:0]       lc;
    logic             hit_any;
    logic [1:0]       hit_idx;
    logic             nonce_emit;
    logic             rec_emit;
    logic [2:0]       end_err;
    logic [2:0]       verdict;
    logic [CMP_W-1:0] cnt_ext;
    logic [SEEN_W-1:0] seen;
    t_result          first_res;
    t_result          end_res;

    // Fold upper-case ASCII letters
    assign lc = (i_data_byte >= "A" && i_data_byte <= "Z") ? (i_data_byte + 8'd32)
                                                           : i_data_byte;

    // Next parse state for this byte
    always_comb begin
        n_phase    = r_phase;
        n_pos      = r_pos;
        n_mask     = r_mask;
        n_status   = r_status;
        n_nonempty = r_nonempty;
        n_count    = r_count;
        n_ovf      = r_ovf;
        n_err      = r_err;
        nonce_emit = 1'b0;
        rec_emit   = 1'b0;
        hit_any    = 1'b0;
        hit_idx    = ST_CONFIRMED;

        // Later words take priority on a full match
        for (int i = 0; i < 3; i++) begin
            if (r_mask[i] && word_len(2'(i)) == r_pos) begin
                hit_any = 1'b1;
                hit_idx = 2'(i);
            end
        end

        unique case (r_phase)
            PH_STATUS: begin
                if (i_data_byte == CH_EQ) begin
                    if (!hit_any) begin
                        n_err   = V_BADWORD;
                        n_phase = PH_DRAIN;
                    end else begin
                        n_status   = hit_idx;
                        n_phase    = PH_NONCE;
                        n_nonempty = 1'b0;
                    end
                end else begin
                    // Drop words that no longer match
                    for (int i = 0; i < 3; i++) begin
                        if (r_pos >= word_len(2'(i)) || word_char(2'(i), r_pos) != lc) begin
                            n_mask[i] = 1'b0;
                        end
                    end
                    if (r_pos != 4'hF) begin
                        n_pos = r_pos + 4'd1;
                    end
                end
            end
            PH_NONCE: begin
                if (i_data_byte == CH_CR) begin
                    n_phase = PH_CR;
                end else begin
                    n_nonempty = 1'b1;
                    nonce_emit = 1'b1;
                end
            end
            PH_CR: begin
                if (i_data_byte != CH_LF) begin
                    n_err   = V_NOLF;
                    n_phase = PH_DRAIN;
                end else if (!r_nonempty) begin
                    n_err   = V_EMPTY;
                    n_phase = PH_DRAIN;
                end else begin
                    if (r_count == {COUNT_WIDTH{1'b1}}) begin
                        n_ovf = 1'b1;
                    end else begin
                        n_count = r_count + COUNT_WIDTH'(1);
                    end
                    rec_emit   = 1'b1;
                    n_phase    = PH_STATUS;
                    n_pos      = 4'd0;
                    n_mask     = 3'b111;
                    n_nonempty = 1'b0;
                end
            end
            PH_DRAIN: begin
                // Ignore bytes after an error
            end
        endcase
    end

    // Work out the verdict for a message end
    always_comb begin
        end_err = n_err;
        if (n_err == V_OK) begin
            if (n_phase == PH_NONCE || n_phase == PH_CR) begin
                end_err = V_UNTERM;
            end else if (n_phase == PH_STATUS && n_pos != 4'd0) begin
                end_err = V_TRAIL;
            end
        end
        cnt_ext = CMP_W'(n_count);
        if (end_err != V_OK) begin
            verdict = end_err;
        end else if (n_count == '0 || n_ovf || cnt_ext != CMP_W'(i_expected_count)) begin
            verdict = V_COUNT;
        end else begin
            verdict = V_OK;
        end
        seen = (cnt_ext > CMP_W'({SEEN_W{1'b1}})) ? {SEEN_W{1'b1}} : cnt_ext[SEEN_W-1:0];
    end

    // Build the result beats
    always_comb begin
        first_res.kind         = rec_emit ? KIND_REC_END : KIND_NONCE;
        first_res.nonce_byte   = rec_emit ? 8'h00 : i_data_byte;
        first_res.entry_status = n_status;
        first_res.verdict      = V_OK;
        first_res.records_seen = seen;
        first_res.last_of_run  = !i_end_of_message;

        end_res.kind         = KIND_MSG_END;
        end_res.nonce_byte   = 8'h00;
        end_res.entry_status = n_status;
        end_res.verdict      = verdict;
        end_res.records_seen = seen;
        end_res.last_of_run  = 1'b1;

        o_push.r1 = end_res;
        if (nonce_emit || rec_emit) begin
            o_push.r0  = first_res;
            o_push.cnt = i_end_of_message ? 2'd2 : 2'd1;
        end else begin
            o_push.r0  = end_res;
            o_push.cnt = i_end_of_message ? 2'd1 : 2'd0;
        end
        if (!i_accept) begin
            o_push.cnt = 2'd0;
        end
    end

    // Advance the state; clear it after a message end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_STATUS;
            r_pos      <= 4'd0;
            r_mask     <= 3'b111;
            r_status   <= ST_UNKNOWN;
            r_nonempty <= 1'b0;
            r_count    <= '0;
            r_ovf      <= 1'b0;
            r_err      <= V_OK;
        end else if (i_accept) begin
            if (i_end_of_message) begin
                r_phase    <= PH_STATUS;
                r_pos      <= 4'd0;
                r_mask     <= 3'b111;
                r_status   <= ST_UNKNOWN;
                r_nonempty <= 1'b0;
                r_count    <= '0;
                r_ovf      <= 1'b0;
                r_err      <= V_OK;
            end else begin
                r_phase    <= n_phase;
                r_pos      <= n_pos;
                r_mask     <= n_mask;
                r_status   <= n_status;
                r_nonempty <= n_nonempty;
                r_count    <= n_count;
                r_ovf      <= n_ovf;
                r_err      <= n_err;
            end
        end
    end

endmodule

// File: src/drp_resq.sv
// ----------------------------------------------------------------------------
// drp_resq - result queue
// Small queue that takes up to two result beats a cycle and hands out one
// beat a cycle on the output channel while the receiver is ready.
// ----------------------------------------------------------------------------
module drp_resq (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  drp_pkg::t_push           i_push,
    input  logic                     i_pop,
    output drp_pkg::t_result         o_head,
    output logic [drp_pkg::LVL_W-1:0] o_level
);
    import drp_pkg::*;

    t_result          r_mem [FIFO_DEPTH];
    logic [PTR_W-1:0] r_wp, n_wp;
    logic [PTR_W-1:0] r_rp, n_rp;
    logic [LVL_W-1:0] r_level, n_level;

    // Pointer and level updates
    always_comb begin
        n_wp    = r_wp + PTR_W'(i_push.cnt);
        n_rp    = i_pop ? (r_rp + PTR_W'(1)) : r_rp;
        n_level = r_level + LVL_W'(i_push.cnt) - LVL_W'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_level <= '0;
        end else begin
            r_wp    <= n_wp;
            r_rp    <= n_rp;
            r_level <= n_level;
        end
    end

    // Store pushed beats in order
    always_ff @(posedge i_clk) begin
        if (i_push.cnt != 2'd0) begin
            r_mem[r_wp] <= i_push.r0;
        end
        if (i_push.cnt == 2'd2) begin
            r_mem[r_wp + PTR_W'(1)] <= i_push.r1;
        end
    end

    assign o_head  = r_mem[r_rp];
    assign o_level = r_level;

endmodule
